/* rtl/core/point_segment_distance_3d_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the point-to-segment distance unit
// Shared same-cycle and next-cycle implication checks, clocked on clk, disabled by rst.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_3D_UNIT_DEFINES_SVH

// same-cycle implication
`define PSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, constants and types of the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int CW    = 24;            // coordinate
  localparam int TF    = 16;            // t fraction bits
  localparam int DW    = CW + 1;        // coordinate difference
  localparam int PW    = 2 * DW;        // product of two differences
  localparam int DOTW  = PW + 2;        // dot product
  localparam int AMW   = PW + 1;        // dot magnitude
  localparam int NW    = AMW + TF + 1;  // dividend
  localparam int DENW  = PW + 1;        // divisor 2*l2
  localparam int RW    = DENW + 1;      // divider remainder
  localparam int QB    = CW + TF + 2;   // quotient bits
  localparam int QH    = QB / 2;
  localparam int PPW   = QH + DW;       // partial product
  localparam int PRW   = QB + DW;       // full t*|d|
  localparam int MVW   = PRW - TF;
  localparam int MGW   = CW + 2;        // saturated offset
  localparam int VW    = CW + 3;
  localparam int DISTW = 2 * CW + 2;
  localparam int RTW   = DISTW / 2;     // root bits
  localparam int SRW   = RTW + 3;       // root remainder
  localparam int IN_W  = 9 * CW;
  localparam int IN_DW = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = DISTW + 3 * CW;
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

  localparam logic [QB-1:0]         ONE_T = QB'(1) << TF;
  localparam logic [MGW-1:0]        LIM   = MGW'(1) << (CW + 1);
  localparam logic [PRW-1:0]        RND   = PRW'(1) << (TF - 1);
  localparam logic signed [VW-1:0]  CMAX  = VW'((1 << (CW - 1)) - 1);
  localparam logic signed [VW-1:0]  CMIN  = ~CMAX;

  localparam logic KIND_SEGMENT = 1'b0;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  typedef struct packed {
    logic         kind;
    logic         sq;
    coord_t [2:0] p;
    coord_t [2:0] a;
    diff_t  [2:0] d;
  } geo_t;

  typedef struct packed {
    geo_t g;
    logic dneg;
    logic zero;
  } dside_t;

  typedef struct packed {
    logic         sq;
    coord_t [2:0] q;
  } oside_t;

endpackage

/* rtl/core/psd_front.sv */
// ----------------------------------------------------------------------------
// psd_front
// Differences, products, dot and |d|^2, then dividend and divisor.
// ----------------------------------------------------------------------------
module psd_front import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic             kind,
  input  logic             sq,
  input  coord_t [2:0]     p,
  input  coord_t [2:0]     a,
  input  coord_t [2:0]     b,
  output logic             out_valid,
  output logic [NW-1:0]    num,
  output logic [DENW-1:0]  den,
  output dside_t           side
);

  logic                v1, v2, v3;
  geo_t                g1, g2, g3;
  logic [DW-1:0]       w1 [3];
  logic signed [PW-1:0] pw2 [3];
  logic signed [PW-1:0] pd2 [3];
  logic [DOTW-1:0]     dot3;
  logic [PW-1:0]       l23;
  logic [DOTW-1:0]     am;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1.kind <= kind;
      g1.sq   <= sq;
      g1.p    <= p;
      g1.a    <= a;
      for (int i = 0; i < 3; i++) begin
        g1.d[i] <= {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
        w1[i]   <= {p[i][CW-1], p[i]} - {a[i][CW-1], a[i]};
      end
      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        pw2[i] <= $signed(w1[i]) * $signed(g1.d[i]);
        pd2[i] <= $signed(g1.d[i]) * $signed(g1.d[i]);
      end
      g3   <= g2;
      dot3 <= {{2{pw2[0][PW-1]}}, pw2[0]} + {{2{pw2[1][PW-1]}}, pw2[1]}
            + {{2{pw2[2][PW-1]}}, pw2[2]};
      l23  <= pd2[0] + pd2[1] + pd2[2];
      side.g    <= g3;
      side.dneg <= dot3[DOTW-1];
      side.zero <= (l23 == '0);
      num       <= {am[AMW-1:0], {(TF + 1){1'b0}}} + NW'(l23);
      den       <= {l23, 1'b0};
    end
  end

  assign am = dot3[DOTW-1] ? (~dot3 + DOTW'(1)) : dot3;

endmodule

/* rtl/core/psd_div.sv */
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module psd_div import psd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NW-1:0]    num,
  input  logic [DENW-1:0]  den,
  input  dside_t           side_in,
  output logic             out_valid,
  output logic [QB-1:0]    quo,
  output dside_t           side_out
);

  logic            v_r    [QB];
  logic [RW-1:0]   rem_r  [QB];
  logic [QB-1:0]   bits_r [QB];
  logic [QB-1:0]   quo_r  [QB];
  logic [DENW-1:0] den_r  [QB];
  dside_t          side_r [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_step
      logic            v_p;
      logic [RW-1:0]   rem_p;
      logic [QB-1:0]   bits_p;
      logic [QB-1:0]   quo_p;
      logic [DENW-1:0] den_p;
      dside_t          side_p;
      logic [RW-1:0]   shl;
      logic            ge;

      if (k == 0) begin : g_first
        assign v_p    = in_valid;
        assign rem_p  = RW'(num[NW-1:QB]);
        assign bits_p = num[QB-1:0];
        assign quo_p  = '0;
        assign den_p  = den;
        assign side_p = side_in;
      end else begin : g_next
        assign v_p    = v_r[k-1];
        assign rem_p  = rem_r[k-1];
        assign bits_p = bits_r[k-1];
        assign quo_p  = quo_r[k-1];
        assign den_p  = den_r[k-1];
        assign side_p = side_r[k-1];
      end

      assign shl = {rem_p[RW-2:0], bits_p[QB-1]};
      assign ge  = (shl >= RW'(den_p));

      always_ff @(posedge clk) begin
        if (rst) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? (shl - RW'(den_p)) : shl;
          bits_r[k] <= {bits_p[QB-2:0], 1'b0};
          quo_r[k]  <= {quo_p[QB-2:0], ge};
          den_r[k]  <= den_p;
          side_r[k] <= side_p;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[QB-1];
  assign quo       = quo_r[QB-1];
  assign side_out  = side_r[QB-1];

endmodule

/* rtl/core/psd_proj.sv */
// ----------------------------------------------------------------------------
// psd_proj
// Clamps t to [0,1] for segments, forms a + t*d per axis with rounding and saturation.
// ----------------------------------------------------------------------------
`include "point_segment_distance_3d_unit_defines.svh"

module psd_proj import psd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [QB-1:0] quo,
  input  dside_t        side,
  output logic          out_valid,
  output coord_t [2:0]  p_out,
  output oside_t        o_out
);

  logic             v_a, v_b, v_c;
  logic [QB-1:0]    t_a;
  logic             tneg_a;
  geo_t             g_a, g_b, g_c;
  logic [PPW-1:0]   lo_b [3];
  logic [PPW-1:0]   hi_b [3];
  logic             neg_b [3];
  logic [MGW-1:0]   mc_c [3];
  logic             neg_c [3];
  logic [QB-1:0]    tm;
  logic             tn;
  logic [DW-1:0]    mg [3];
  logic [PRW-1:0]   prod [3];
  logic [MVW-1:0]   mv [3];
  logic signed [VW-1:0] va [3];

  always_comb begin
    tm = side.zero ? '0 : quo;
    tn = side.dneg && (tm != '0);
    if (side.g.kind == KIND_SEGMENT) begin
      if (tn) begin
        tm = '0;
      end else if (tm > ONE_T) begin
        tm = ONE_T;
      end
      tn = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i]   = g_a.d[i][DW-1] ? (~g_a.d[i] + DW'(1)) : g_a.d[i];
      prod[i] = {hi_b[i], {QH{1'b0}}} + PRW'(lo_b[i]) + RND;
      mv[i]   = prod[i][PRW-1:TF];
      va[i]   = neg_c[i] ? ({{3{g_c.a[i][CW-1]}}, g_c.a[i]} - {1'b0, mc_c[i]})
                         : ({{3{g_c.a[i][CW-1]}}, g_c.a[i]} + {1'b0, mc_c[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      out_valid <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a    <= tm;
      tneg_a <= tn;
      g_a    <= side.g;
      g_b    <= g_a;
      g_c    <= g_b;
      for (int i = 0; i < 3; i++) begin
        lo_b[i]  <= PPW'(t_a[QH-1:0]) * PPW'(mg[i]);
        hi_b[i]  <= PPW'(t_a[QB-1:QH]) * PPW'(mg[i]);
        neg_b[i] <= tneg_a ^ g_a.d[i][DW-1];
        mc_c[i]  <= (mv[i] > MVW'(LIM)) ? LIM : mv[i][MGW-1:0];
        neg_c[i] <= neg_b[i];
        if (va[i] > CMAX) begin
          o_out.q[i] <= CMAX[CW-1:0];
        end else if (va[i] < CMIN) begin
          o_out.q[i] <= CMIN[CW-1:0];
        end else begin
          o_out.q[i] <= va[i][CW-1:0];
        end
      end
      p_out    <= g_c.p;
      o_out.sq <= g_c.sq;
    end
  end

  `PSD_ASSERT_NOW(a_seg_t_range, v_a && (g_a.kind == KIND_SEGMENT),
                  (t_a <= ONE_T) && !tneg_a, "segment t outside [0,1]")
  `PSD_ASSERT_NOW(a_tneg_nonzero, v_a && tneg_a, t_a != '0, "negative t with zero magnitude")
  `PSD_ASSERT_NOW(a_offset_limit, v_c,
                  (mc_c[0] <= LIM) && (mc_c[1] <= LIM) && (mc_c[2] <= LIM),
                  "projection offset above limit")
  `PSD_ASSERT_NEXT(a_stall_hold, !en,
                   $stable(o_out.q[0]) && $stable(o_out.q[1]) && $stable(o_out.q[2]),
                   "projection changed during stall")

endmodule

/* rtl/core/psd_sqrt.sv */
// ----------------------------------------------------------------------------
// psd_sqrt
// Squared error sum and pipelined rounded square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  coord_t [2:0]      p,
  input  oside_t            o_in,
  output logic              out_valid,
  output logic [DISTW-1:0]  dist_val,
  output coord_t [2:0]      q
);

  logic              v_e, v_f, v_g;
  logic signed [DW-1:0] e_e [3];
  logic [PW-1:0]     e2_f [3];
  logic [DISTW-1:0]  s_g;
  oside_t            o_e, o_f, o_g;

  logic              v_r    [RTW];
  logic [SRW-1:0]    rem_r  [RTW];
  logic [RTW-1:0]    root_r [RTW];
  logic [DISTW-1:0]  s_r    [RTW];
  oside_t            o_r    [RTW];
  logic [RTW:0]      rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
    end else if (en) begin
      v_e <= in_valid;
      v_f <= v_e;
      v_g <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_e[i]  <= {p[i][CW-1], p[i]} - {o_in.q[i][CW-1], o_in.q[i]};
        e2_f[i] <= e_e[i] * e_e[i];
      end
      o_e <= o_in;
      o_f <= o_e;
      o_g <= o_f;
      s_g <= e2_f[0] + e2_f[1] + e2_f[2];
    end
  end

  genvar j;
  generate
    for (j = 0; j < RTW; j++) begin : g_root
      logic             v_p;
      logic [SRW-1:0]   rem_p;
      logic [RTW-1:0]   root_p;
      logic [DISTW-1:0] s_p;
      oside_t           o_p;
      logic [SRW-1:0]   shl;
      logic [SRW-1:0]   trial;
      logic             ge;

      if (j == 0) begin : g_first
        assign v_p    = v_g;
        assign rem_p  = '0;
        assign root_p = '0;
        assign s_p    = s_g;
        assign o_p    = o_g;
      end else begin : g_next
        assign v_p    = v_r[j-1];
        assign rem_p  = rem_r[j-1];
        assign root_p = root_r[j-1];
        assign s_p    = s_r[j-1];
        assign o_p    = o_r[j-1];
      end

      assign shl   = {rem_p[SRW-3:0], s_p[DISTW-1-2*j -: 2]};
      assign trial = {{(SRW-RTW-2){1'b0}}, root_p, 2'b01};
      assign ge    = (shl >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          v_r[j] <= 1'b0;
        end else if (en) begin
          v_r[j] <= v_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j]  <= ge ? (shl - trial) : shl;
          root_r[j] <= {root_p[RTW-2:0], ge};
          s_r[j]    <= s_p;
          o_r[j]    <= o_p;
        end
      end
    end
  endgenerate

  assign rnd = (rem_r[RTW-1] > SRW'(root_r[RTW-1]))
             ? ({1'b0, root_r[RTW-1]} + (RTW+1)'(1))
             : {1'b0, root_r[RTW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[RTW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_val <= o_r[RTW-1].sq ? s_r[RTW-1] : DISTW'(rnd);
      q        <= o_r[RTW-1].q;
    end
  end

endmodule

/* rtl/core/point_segment_distance_3d_unit.sv */
// ----------------------------------------------------------------------------
// point_segment_distance_3d_unit
// Distance from a 3D point to a segment or infinite line, with projection.
// ----------------------------------------------------------------------------
// Input stream s_*: one query per beat. s_tdata carries point, start and end
// coordinates, signed Q16.8; s_tuser carries kind (segment or line) and the
// squared/plain flag. Output stream m_*: one result per query, in order:
// distance (squared in Q.16, or rounded root in Q.8) and the projection.
// Each query passes in order through differences, products and sums, the
// one-bit-per-stage divider, clamp and projection, the error sum, and the
// one-bit-per-stage square root and final select.
// Throughput is one query per cycle while the output is not stalled.
// The whole pipeline advances together; when m_tvalid is high and m_tready
// low every stage holds and s_tready drops, so no beat is lost or repeated.
// Reset clears all valid bits; the first query may follow on the next cycle.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_unit import psd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // point_x, point_y, point_z, start_x/y/z, end_x/y/z
  input  logic [1:0]        s_tuser,   // kind, want_squared
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata    // dist_value, proj_x, proj_y, proj_z, zero pad
);

  logic             en;
  coord_t [2:0]     pin, ain, bin;
  logic             f_valid, d_valid, p_valid;
  logic [NW-1:0]    num;
  logic [DENW-1:0]  den;
  dside_t           f_side, d_side;
  logic [QB-1:0]    quo;
  coord_t [2:0]     pp;
  oside_t           po;
  logic [DISTW-1:0] dist_val;
  coord_t [2:0]     q;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pin[i] = s_tdata[i*CW +: CW];
      ain[i] = s_tdata[(i+3)*CW +: CW];
      bin[i] = s_tdata[(i+6)*CW +: CW];
    end
  end

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .kind      (s_tuser[0]),
    .sq        (s_tuser[1]),
    .p         (pin),
    .a         (ain),
    .b         (bin),
    .out_valid (f_valid),
    .num       (num),
    .den       (den),
    .side      (f_side)
  );

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (num),
    .den       (den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quo       (quo),
    .side_out  (d_side)
  );

  psd_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .quo       (quo),
    .side      (d_side),
    .out_valid (p_valid),
    .p_out     (pp),
    .o_out     (po)
  );

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .p         (pp),
    .o_in      (po),
    .out_valid (m_tvalid),
    .dist_val  (dist_val),
    .q         (q)
  );

  assign m_tdata = {{(OUT_DW-OUT_W){1'b0}}, q[2], q[1], q[0], dist_val};

endmodule
